[rtl/cht_pkg.sv]
// shared types, codes and constants of the cuckoo hash table
`default_nettype none

package cht_pkg;

    localparam int KEY_W       = 64;
    localparam int BLOCK_W     = 31;
    localparam int WAY_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 16;
    localparam int FOLD_CHUNKS = KEY_W / 8;
    localparam logic [CFG_W-1:0] MAX_EVICT_RESET = 16'd10000;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

    typedef struct packed {
        logic               func;
        logic [KEY_W-1:0]   key;
        logic [BLOCK_W-1:0] block;
        logic [WAY_W-1:0]   way;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WAY_W-1:0]    way;
        logic [KEY_W-1:0]    key;
        logic [BLOCK_W-1:0]  block;
        logic                last;
    } result_t;

    typedef logic [FOLD_CHUNKS-1:0][31:0] weights_t;

    // divisor of the index function of each way
    function automatic logic [31:0] way_div(input int w, input int slots);
        logic [31:0] d;
        case (w)
            0: d = 32'd337;
            1: d = 32'd10003;
            2: d = 32'd11;
            3: d = 32'd23;
            4: d = 32'd17;
            5: d = 32'(slots);
            default: d = 32'd1;
        endcase
        return d;
    endfunction

    // weight of each key byte in the residue modulo an odd divisor
    function automatic weights_t fold_weights(input logic [31:0] d);
        weights_t wt;
        for (int i = 0; i < FOLD_CHUNKS; i++)
        begin
            wt[i] = 32'((64'd1 << (8 * i)) % 64'(d));
        end
        return wt;
    endfunction

    // floor of 2^32 over the divisor
    function automatic logic [31:0] recip(input logic [31:0] d);
        return 32'((64'd1 << 32) / 64'(d));
    endfunction

    // inverse of an odd divisor modulo 2^32, newton iteration
    function automatic logic [31:0] odd_inverse(input logic [31:0] d);
        logic [31:0] x;
        x = d;
        for (int i = 0; i < 5; i++)
        begin
            x = x * (32'd2 - d * x);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

[rtl/cht_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module cht_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/cht_hash.sv]
// index unit: per-way key division by constants through a residue fold and a reciprocal multiply
`default_nettype none

module cht_hash #(
    parameter int WAYS          = 4,
    parameter int SLOTS_PER_WAY = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [cht_pkg::KEY_W-1:0]     key,
    output logic                               done,
    output logic [WAYS-1:0][$clog2(SLOTS_PER_WAY)-1:0] idx
);

    localparam int IDX_W = $clog2(SLOTS_PER_WAY);

    logic [3:0]                 stage_reg;
    logic                       done_reg;
    logic [cht_pkg::KEY_W-1:0]  key_reg;
    logic [WAYS-1:0][IDX_W-1:0] lane_idx;
    logic [WAYS-1:0][IDX_W-1:0] idx_reg;

    for (genvar w = 0; w < WAYS; w++)
    begin : g_lane
        localparam logic [31:0] DIV = cht_pkg::way_div(w, SLOTS_PER_WAY);
        if (DIV == 32'd1)
        begin : g_unit
            assign lane_idx[w] = key_reg[IDX_W-1:0];
        end
        else if (DIV == 32'(SLOTS_PER_WAY))
        begin : g_shift
            assign lane_idx[w] = key_reg[2*IDX_W-1:IDX_W];
        end
        else
        begin : g_odd
            localparam cht_pkg::weights_t WEIGHT = cht_pkg::fold_weights(DIV);
            localparam logic [31:0] RECIP = cht_pkg::recip(DIV);
            localparam logic [31:0] INV   = cht_pkg::odd_inverse(DIV);

            logic [31:0]      sum_reg;
            logic [31:0]      sum_next;
            logic [31:0]      quo_reg;
            logic [63:0]      quo_prod;
            logic [31:0]      rem_reg;
            logic [31:0]      rem_raw;
            logic [31:0]      rem_next;
            logic [IDX_W-1:0] diff;

            // sum congruent to the key modulo the divisor, folded byte by byte
            always_comb
            begin
                sum_next = '0;
                for (int i = 0; i < cht_pkg::FOLD_CHUNKS; i++)
                begin
                    sum_next = sum_next + 32'(key_reg[8*i +: 8]) * WEIGHT[i];
                end
            end

            // quotient estimate is exact or one low
            assign quo_prod = 64'(sum_reg) * 64'(RECIP);
            assign rem_raw  = sum_reg - quo_reg * DIV;
            assign rem_next = (rem_raw >= DIV) ? rem_raw - DIV : rem_raw;

            // low quotient bits from the exact multiple of the divisor
            assign diff        = key_reg[IDX_W-1:0] - rem_reg[IDX_W-1:0];
            assign lane_idx[w] = IDX_W'(diff * INV[IDX_W-1:0]);

            always_ff @(posedge clk)
            begin
                if (stage_reg[0])
                begin
                    sum_reg <= sum_next;
                end
                if (stage_reg[1])
                begin
                    quo_reg <= quo_prod[63:32];
                end
                if (stage_reg[2])
                begin
                    rem_reg <= rem_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[2:0], start};
            done_reg  <= stage_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
        end
        if (stage_reg[3])
        begin
            idx_reg <= lane_idx;
        end
    end

    assign done = done_reg;
    assign idx  = idx_reg;

endmodule

`default_nettype wire

[rtl/cht_front.sv]
// front end: accepts requests, computes way indices, queues them
`default_nettype none

module cht_front #(
    parameter int WAYS          = 4,
    parameter int SLOTS_PER_WAY = 1024
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cht_pkg::item_t in_item,
    output logic                q_valid,
    output cht_pkg::item_t      q_item,
    output logic [WAYS-1:0][$clog2(SLOTS_PER_WAY)-1:0] q_idx,
    input  wire logic           q_pop
);

    localparam int IDX_W = $clog2(SLOTS_PER_WAY);
    localparam int QD    = 2;

    logic           busy_reg;
    cht_pkg::item_t item_reg;
    cht_pkg::item_t item_in;
    logic           hash_done;
    logic [WAYS-1:0][IDX_W-1:0] hash_idx;

    cht_pkg::item_t              qi_reg  [QD];
    logic [WAYS-1:0][IDX_W-1:0]  qx_reg  [QD];
    logic                        wptr_reg;
    logic                        rptr_reg;
    logic [1:0]                  count_reg;
    logic                        accept;

    always_comb
    begin
        logic [cht_pkg::WAY_W-1:0] w;
        item_in = in_item;
        w = in_item.way;
        for (int i = 0; i < 4; i++)
        begin
            if (w >= cht_pkg::WAY_W'(WAYS))
            begin
                w = w - cht_pkg::WAY_W'(WAYS);
            end
        end
        item_in.way = w;
    end

    assign in_ready = !busy_reg && (count_reg < 2'(QD));
    assign accept   = in_valid && in_ready;

    cht_hash #(
        .WAYS          (WAYS),
        .SLOTS_PER_WAY (SLOTS_PER_WAY)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (in_item.key),
        .done  (hash_done),
        .idx   (hash_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (hash_done)
            begin
                busy_reg <= 1'b0;
            end
            if (hash_done)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + 2'(hash_done) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
        if (hash_done)
        begin
            qi_reg[wptr_reg] <= item_reg;
            qx_reg[wptr_reg] <= hash_idx;
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = qi_reg[rptr_reg];
    assign q_idx   = qx_reg[rptr_reg];

endmodule

`default_nettype wire

[rtl/cht_back.sv]
// back end: table clear, lookup probes, insert eviction walk, result register
`default_nettype none

module cht_back #(
    parameter int WAYS          = 4,
    parameter int SLOTS_PER_WAY = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [cht_pkg::CFG_W-1:0]    max_evictions,
    input  wire logic                         q_valid,
    input  wire cht_pkg::item_t               q_item,
    input  wire logic [WAYS-1:0][$clog2(SLOTS_PER_WAY)-1:0] q_idx,
    output logic                              q_pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output cht_pkg::result_t                  m_res
);

    localparam int IDX_W  = $clog2(SLOTS_PER_WAY);
    localparam int WAY_AW = $clog2(WAYS);
    localparam int ADDR_W = WAY_AW + IDX_W;
    localparam int DEPTH  = WAYS * SLOTS_PER_WAY;
    localparam int DW     = 1 + cht_pkg::KEY_W + cht_pkg::BLOCK_W;
    localparam int WW     = cht_pkg::WAY_W;

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_LK_RD    = 9'b000000100,
        S_LK_CHK   = 9'b000001000,
        S_LK_END   = 9'b000010000,
        S_INS_TST  = 9'b000100000,
        S_INS_CHK  = 9'b001000000,
        S_INS_HASH = 9'b010000000,
        S_INS_END  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [ADDR_W-1:0]               clr_reg;
    logic [cht_pkg::KEY_W-1:0]       cur_key_reg;
    logic [cht_pkg::BLOCK_W-1:0]     cur_block_reg;
    logic [WW-1:0]                   cur_way_reg;
    logic [WW-1:0]                   lk_way_reg;
    logic [WAYS-1:0][IDX_W-1:0]      idx_reg;
    logic [cht_pkg::CFG_W-1:0]       evict_reg;
    logic                            dropped_reg;
    logic                            pend_reg;
    logic [WW-1:0]                   pend_way_reg;
    logic [cht_pkg::BLOCK_W-1:0]     pend_block_reg;
    logic                            out_valid_reg;
    cht_pkg::result_t                out_reg;

    logic                            ram_we;
    logic                            ram_re;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [ADDR_W-1:0]               ram_raddr;
    logic [DW-1:0]                   ram_wdata;
    logic [DW-1:0]                   ram_rdata;
    logic                            rd_valid;
    logic [cht_pkg::KEY_W-1:0]       rd_key;
    logic [cht_pkg::BLOCK_W-1:0]     rd_block;
    logic [ADDR_W-1:0]               ins_addr;
    logic [ADDR_W-1:0]               lk_addr;
    logic                            out_free;
    logic                            hit;
    logic                            lk_stall;
    logic                            emit;
    cht_pkg::result_t                emit_res;
    logic                            hash_start;
    logic                            hash_done;
    logic [WAYS-1:0][IDX_W-1:0]      hash_idx;
    logic [WW-1:0]                   next_way;

    assign {rd_valid, rd_key, rd_block} = ram_rdata;
    assign ins_addr = {cur_way_reg[WAY_AW-1:0], idx_reg[cur_way_reg[WAY_AW-1:0]]};
    assign lk_addr  = {lk_way_reg[WAY_AW-1:0], idx_reg[lk_way_reg[WAY_AW-1:0]]};
    assign out_free = !out_valid_reg || m_ready;
    assign hit      = rd_valid && (rd_key == cur_key_reg);
    assign lk_stall = hit && pend_reg && !out_free;
    assign next_way = (cur_way_reg == WW'(WAYS - 1)) ? '0 : cur_way_reg + WW'(1);

    cht_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cht_hash #(
        .WAYS          (WAYS),
        .SLOTS_PER_WAY (SLOTS_PER_WAY)
    ) u_rehash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (rd_key),
        .done  (hash_done),
        .idx   (hash_idx)
    );

    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = ins_addr;
        ram_raddr  = ins_addr;
        ram_wdata  = {1'b1, cur_key_reg, cur_block_reg};
        q_pop      = 1'b0;
        hash_start = 1'b0;
        emit       = 1'b0;
        emit_res   = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = (q_item.func == cht_pkg::FUNC_LOOKUP) ? S_LK_RD : S_INS_TST;
                end
            end
            S_LK_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = lk_addr;
                state_next = S_LK_CHK;
            end
            S_LK_CHK:
            begin
                if (!lk_stall)
                begin
                    emit = hit && pend_reg;
                    emit_res = '{cht_pkg::ST_HIT, pend_way_reg, cur_key_reg,
                                 pend_block_reg, 1'b0};
                    state_next = (lk_way_reg == WW'(WAYS - 1)) ? S_LK_END : S_LK_RD;
                end
            end
            S_LK_END:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pend_reg)
                    begin
                        emit_res = '{cht_pkg::ST_HIT, pend_way_reg, cur_key_reg,
                                     pend_block_reg, 1'b1};
                    end
                    else
                    begin
                        emit_res = '{cht_pkg::ST_MISS, '0, '0, '0, 1'b1};
                    end
                    state_next = S_IDLE;
                end
            end
            S_INS_TST:
            begin
                if (evict_reg >= max_evictions)
                begin
                    state_next = S_INS_END;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_INS_CHK;
                end
            end
            S_INS_CHK:
            begin
                ram_we = 1'b1;
                if (rd_valid)
                begin
                    hash_start = 1'b1;
                    state_next = S_INS_HASH;
                end
                else
                begin
                    state_next = S_INS_END;
                end
            end
            S_INS_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_INS_TST;
                end
            end
            S_INS_END:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (dropped_reg)
                    begin
                        emit_res = '{cht_pkg::ST_DROPPED, cur_way_reg, cur_key_reg,
                                     cur_block_reg, 1'b1};
                    end
                    else
                    begin
                        emit_res = '{cht_pkg::ST_PLACED, cur_way_reg, '0, '0, 1'b1};
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            evict_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop && q_item.func == cht_pkg::FUNC_INSERT)
            begin
                evict_reg <= '0;
            end
            else if (state_reg == S_INS_CHK && rd_valid)
            begin
                evict_reg <= evict_reg + cht_pkg::CFG_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= emit_res;
        end
        if (q_pop)
        begin
            cur_key_reg   <= q_item.key;
            cur_block_reg <= q_item.block;
            cur_way_reg   <= q_item.way;
            idx_reg       <= q_idx;
            lk_way_reg    <= '0;
            pend_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        if (state_reg == S_LK_CHK && !lk_stall)
        begin
            if (hit)
            begin
                pend_reg       <= 1'b1;
                pend_way_reg   <= lk_way_reg;
                pend_block_reg <= rd_block;
            end
            lk_way_reg <= lk_way_reg + WW'(1);
        end
        if (state_reg == S_INS_TST && evict_reg >= max_evictions)
        begin
            dropped_reg <= 1'b1;
        end
        if (state_reg == S_INS_CHK && rd_valid)
        begin
            cur_key_reg   <= rd_key;
            cur_block_reg <= rd_block;
            cur_way_reg   <= next_way;
        end
        if (state_reg == S_INS_HASH && hash_done)
        begin
            idx_reg <= hash_idx;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_INS_CHK))
        else $error("table written outside clear or insert");

    a_rehash_done: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == S_INS_HASH)
        else $error("rehash finished while not waiting for it");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_ready) |=> $stable(out_reg))
        else $error("pending result overwritten");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop && !emit)
        else $error("request taken during table clear");

endmodule

`default_nettype wire

[rtl/cuckoo_hash_table.sv]
// top level of the multi-way cuckoo hash table
//
// channel  direction  tdata (low bit up)                      tuser   tlast
// s_axis   in         key[63:0] block_value[94:64] start_way   func    -
// m_axis   out        way[2:0] out_key[66:3] out_block[97:67]  status  last
// cfg      in         cfg_wr_data = max_evictions              -       -
//
// way indices come from a residue fold and a reciprocal multiply
// the front unit takes no new request until the last one is hashed, and each eviction waits on a rehash
// the back unit reads and checks each way in turn for a lookup, and for an insert swaps one slot per eviction
// after reset the table ram is cleared slot by slot before requests run
// the front queue holds two requests, so input and output stall independently
`default_nettype none

module cuckoo_hash_table #(
    parameter int WAYS          = 4,
    parameter int SLOTS_PER_WAY = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [103:0]  s_axis_tdata,   // key, block_value, start_way
    input  wire logic          s_axis_tuser,   // func
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic      [103:0]  m_axis_tdata,   // way, out_key, out_block
    output logic      [1:0]    m_axis_tuser,   // status
    output logic               m_axis_tlast,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data
);

    localparam int IDX_W = $clog2(SLOTS_PER_WAY);

    logic [cht_pkg::CFG_W-1:0] max_evict_reg;
    cht_pkg::item_t            in_item;
    logic                      q_valid;
    cht_pkg::item_t            q_item;
    logic [WAYS-1:0][IDX_W-1:0] q_idx;
    logic                      q_pop;
    cht_pkg::result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_evict_reg <= cht_pkg::MAX_EVICT_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_evict_reg <= cfg_wr_data;
        end
    end

    assign in_item.func  = s_axis_tuser;
    assign in_item.key   = s_axis_tdata[63:0];
    assign in_item.block = s_axis_tdata[94:64];
    assign in_item.way   = s_axis_tdata[97:95];

    cht_front #(
        .WAYS          (WAYS),
        .SLOTS_PER_WAY (SLOTS_PER_WAY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_idx    (q_idx),
        .q_pop    (q_pop)
    );

    cht_back #(
        .WAYS          (WAYS),
        .SLOTS_PER_WAY (SLOTS_PER_WAY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_evictions (max_evict_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_idx         (q_idx),
        .q_pop         (q_pop),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .m_res         (res)
    );

    assign m_axis_tdata = {6'b0, res.block, res.key, res.way};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
